[hw/rtl/assert_macros.svh]
// Assertion macros shared by the min-tracking stack RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion violated in %m");

// The consequent must hold in the cycle after the antecedent.
`define MTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion violated in %m");

`endif

[hw/rtl/mts_pkg.sv]
// Shared types and constants of the min-tracking stack.
`timescale 1ns / 1ps

package mts_pkg;

  // Operation codes, equal to the input kind encoding.
  typedef logic [1:0] mts_op_t;

  localparam mts_op_t OP_PUSH = 2'd0;
  localparam mts_op_t OP_POP  = 2'd1;
  localparam mts_op_t OP_MIN  = 2'd2;
  localparam mts_op_t OP_NONE = 2'd3;

  localparam int OP_WIDTH = 2;

  // Number of entries in the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Status of the execution part.
  typedef struct packed {
    logic empty;
    logic full;
    logic loading;
  } mts_stat_t;

endpackage

[hw/rtl/mts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mts_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/mts_front.sv]
// Front part: registers incoming requests and filters out undefined kinds.
`timescale 1ns / 1ps

module mts_front #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mts_pkg::mts_op_t       in_kind,
  input  logic [VALUE_WIDTH-1:0] in_push_value,
  output logic                   f_valid,
  input  logic                   f_ready,
  output mts_pkg::mts_op_t       f_op,
  output logic [VALUE_WIDTH-1:0] f_value
);

  logic                   valid_r;
  logic                   valid_nxt;
  mts_pkg::mts_op_t       op_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic                   accept;

  // The holding register frees up when its item moves into the queue.
  assign in_ready = !valid_r || f_ready;
  assign accept   = in_valid && in_ready;

  // A transfer with an undefined kind is taken and dropped here.
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = (in_kind != mts_pkg::OP_NONE);
    end else if (f_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload; the value only matters for a push, so others carry zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_kind;
      value_r <= (in_kind == mts_pkg::OP_PUSH) ? in_push_value : '0;
    end
  end

  assign f_valid = valid_r;
  assign f_op    = op_r;
  assign f_value = value_r;

endmodule

[hw/rtl/mts_fifo.sv]
// Short register queue between the front and back parts.
`timescale 1ns / 1ps

module mts_fifo #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_take,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r;
  logic [PW-1:0]    rd_ptr_nxt;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = entries_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_take && rd_valid;

  // Pointer and fill count update with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[hw/rtl/mts_back.sv]
// Back part: executes stack operations and holds the result register.
`timescale 1ns / 1ps

module mts_back #(
  parameter int DEPTH       = 256,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_take,
  input  mts_pkg::mts_op_t       q_op,
  input  logic [VALUE_WIDTH-1:0] q_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH:0]   out_result_value,
  output mts_pkg::mts_stat_t     stat
);

  localparam int VW = VALUE_WIDTH;
  localparam int EW = VALUE_WIDTH + 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_LOAD = 1'b1;

  logic          state_r;
  logic          state_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [VW-1:0] min_r;
  logic [VW-1:0] min_nxt;
  logic [EW-1:0] top_r;
  logic [EW-1:0] top_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic [EW-1:0] out_value_r;
  logic [EW-1:0] out_value_nxt;

  logic          out_free;
  logic          is_push;
  logic          is_pop;
  logic          empty;
  logic          full;
  logic [EW-1:0] v_ext;
  logic [EW-1:0] min_ext;
  logic          push_gt;
  logic [EW-1:0] push_entry;
  logic          top_below;
  logic [EW-1:0] pop_answer;
  logic [VW-1:0] pop_min;
  logic [CW-1:0] count_m2;
  logic          need_load;
  logic          ram_wr_en;
  logic          ram_rd_en;
  logic [EW-1:0] ram_rd_data;

  assign out_free = !out_valid_r || out_ready;
  assign is_push  = (q_op == mts_pkg::OP_PUSH);
  assign is_pop   = (q_op == mts_pkg::OP_POP);
  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(DEPTH));

  // A push needs no result slot; pop and minimum wait for a free output.
  assign q_take = (state_r == ST_RUN) && q_valid && (is_push || out_free);

  // Push encoding: store the value, or its difference to the old minimum.
  assign v_ext      = {1'b0, q_value};
  assign min_ext    = {1'b0, min_r};
  assign push_gt    = (q_value > min_r);
  assign push_entry = (empty || push_gt) ? v_ext : v_ext - min_ext;

  // Pop decoding: an entry below the minimum marks a minimum change.
  assign top_below  = ($signed(top_r) < $signed(min_ext));
  assign pop_answer = top_below ? min_ext : top_r;
  assign pop_min    = min_r - top_r[VW-1:0];

  // After a pop the entry below becomes the top and is fetched from RAM.
  assign count_m2  = count_r - CW'(2);
  assign need_load = (count_r > CW'(1));
  assign ram_wr_en = q_take && is_push && !full;
  assign ram_rd_en = q_take && is_pop && need_load;

  mts_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (push_entry),
    .rd_en   (ram_rd_en),
    .rd_addr (count_m2[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // Operation sequencer.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    min_nxt       = min_r;
    top_nxt       = top_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    unique case (state_r)
      ST_RUN: begin
        if (q_take) begin
          unique case (q_op)
            mts_pkg::OP_PUSH: begin
              if (!full) begin
                count_nxt = count_r + CW'(1);
                top_nxt   = push_entry;
                if (empty || !push_gt) begin
                  min_nxt = q_value;
                end
              end
            end
            mts_pkg::OP_POP: begin
              out_valid_nxt = 1'b1;
              if (empty) begin
                out_value_nxt = {EW{1'b1}};
              end else begin
                out_value_nxt = pop_answer;
                count_nxt     = count_r - CW'(1);
                if (top_below) begin
                  min_nxt = pop_min;
                end
                if (need_load) begin
                  state_nxt = ST_LOAD;
                end
              end
            end
            mts_pkg::OP_MIN: begin
              out_valid_nxt = 1'b1;
              out_value_nxt = empty ? {EW{1'b1}} : min_ext;
            end
            default: begin
              out_valid_nxt = out_valid_r && !out_ready;
            end
          endcase
        end
      end
      ST_LOAD: begin
        top_nxt   = ram_rd_data;
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      count_r     <= '0;
      min_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r       <= top_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;

  assign stat.empty   = empty;
  assign stat.full    = full;
  assign stat.loading = (state_r == ST_LOAD);

endmodule

[hw/rtl/min_tracking_stack.sv]
// Min-tracking stack: a value stack that reports its minimum in one step.
//
// Input channel in_valid/in_ready carries in_kind (push, pop, get minimum)
// and in_push_value. Result channel out_valid/out_ready carries
// out_result_value, an unsigned word one bit wider than the values that is all ones when the stack is empty.
// A push gives no result and is dropped when the stack is full; an undefined
// kind is taken and dropped. Pop and get minimum each give one result.
// Requests pass a holding register and a two-entry queue before execution.
// A pop that leaves entries behind adds a load state, in which no item is
// taken and the new top of stack is fetched from the entry RAM, whose read
// data is registered. Sustained rate is one item per cycle for pushes, and
// for minimum reads while the receiver takes each result; after such a pop
// the next item waits until the load state ends. Reset (synchronous,
// active low) empties the stack and the queue at once; RAM contents are
// not cleared. When the receiver stalls, the output register holds its
// result, the queue fills, and in_ready drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module min_tracking_stack #(
  parameter int DEPTH       = 256,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_kind,
  input  logic [VALUE_WIDTH-1:0] in_push_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH:0]   out_result_value
);

  localparam int QW = mts_pkg::OP_WIDTH + VALUE_WIDTH;

  logic                   f_valid;
  logic                   f_ready;
  mts_pkg::mts_op_t       f_op;
  logic [VALUE_WIDTH-1:0] f_value;
  logic                   q_valid;
  logic                   q_take;
  logic [QW-1:0]          q_data;
  mts_pkg::mts_stat_t     stat;

  // Front: request register and kind filter.
  mts_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_push_value (in_push_value),
    .f_valid       (f_valid),
    .f_ready       (f_ready),
    .f_op          (f_op),
    .f_value       (f_value)
  );

  // Queue decoupling the front from execution.
  mts_fifo #(
    .WIDTH (QW),
    .DEPTH (mts_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_op, f_value}),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_data  (q_data)
  );

  // Back: stack execution, entry RAM and result register.
  mts_back #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_take           (q_take),
    .q_op             (q_data[QW-1:VALUE_WIDTH]),
    .q_value          (q_data[VALUE_WIDTH-1:0]),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .stat             (stat)
  );

  // The back part only takes an item that the queue holds.
  `MTS_ASSERT_SAME(a_take_needs_item, q_take, q_valid)
  // No new item starts while the top of stack is being fetched.
  `MTS_ASSERT_SAME(a_no_take_while_loading, stat.loading, !q_take)
  // The top-of-stack fetch never lasts into the next cycle.
  `MTS_ASSERT_NEXT(a_load_one_cycle, stat.loading, !stat.loading)
  // A fetch only follows a pop that left entries on the stack.
  `MTS_ASSERT_SAME(a_load_not_empty, stat.loading, !stat.empty)

endmodule
